// ===== rtl/slc_pkg.sv =====
// shared types and character codes for the source line counter
package slc_pkg;

  // scanner modes
  typedef enum logic [2:0] {
    MODE_NORMAL = 3'd0,
    MODE_SLASH  = 3'd1,
    MODE_LINE   = 3'd2,
    MODE_BLOCK  = 3'd3,
    MODE_STAR   = 3'd4,
    MODE_STRING = 3'd5,
    MODE_CHAR   = 3'd6
  } mode_t;

  // word operations
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_END  = 1'b1;

  localparam int unsigned TOTAL_WIDTH = 32;

  // character codes
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_DQ    = 8'h22;
  localparam logic [7:0] CH_SQ    = 8'h27;
  localparam logic [7:0] CH_BS    = 8'h5C;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;

  // input word
  typedef struct packed {
    logic       op;
    logic [7:0] data;
  } in_word_t;

  // result word
  typedef struct packed {
    logic [TOTAL_WIDTH-1:0] total;
    logic                   done;
  } out_word_t;

  // scanner status seen by the top level
  typedef struct packed {
    logic at_rest;
    logic count_full;
  } scan_status_t;

endpackage

// ===== rtl/source_line_counter_top.sv =====
// top level of the source line counter: input register, scanner, result register
// a word passes from the input register through the scanner into the result register, which drives out_valid
// throughput: one word per cycle while out_stall is low, each word giving exactly one result word
// the scanner state updates as a word moves from input to result register
// reset: synchronous, clears the scanner state, both register valids and the
// comment-line switch; no clearing pass
module source_line_counter_top import slc_pkg::*; #(
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        op,
  input  logic [7:0]  byte_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] line_total,
  output logic        file_done,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data
);

  logic                   s1_valid;
  in_word_t               s1_word;
  logic                   s2_valid;
  out_word_t              s2_word;
  logic                   s1_adv;
  logic                   fire;
  logic                   accept;
  logic                   count_comment_lines;
  out_word_t              scan_result;
  logic [COUNT_WIDTH-1:0] count;
  scan_status_t           status;

  // handshake
  assign s1_adv    = !s2_valid || !out_stall;
  assign fire      = s1_valid && s1_adv;
  assign in_stall  = s1_valid && !s1_adv;
  assign accept    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      count_comment_lines <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      count_comment_lines <= cfg_data;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept || (s1_valid && !s1_adv);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_word.op   <= op;
      s1_word.data <= byte_in;
    end
  end

  slc_scan #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_scan (
    .clk                 (clk),
    .rst                 (rst),
    .fire                (fire),
    .word                (s1_word),
    .count_comment_lines (count_comment_lines),
    .result              (scan_result),
    .count               (count),
    .status              (status)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= fire || (s2_valid && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      s2_word <= scan_result;
    end
  end

  assign out_valid  = s2_valid;
  assign line_total = s2_word.total;
  assign file_done  = s2_word.done;

  // the input side only stalls while the input register holds a word
  assert property (@(posedge clk) disable iff (rst) in_stall |-> s1_valid)
    else $error("input stalled with empty input register");

  // an end word leaves the scanner at rest
  assert property (@(posedge clk) disable iff (rst)
                   (fire && s1_word.op == OP_END) |=> status.at_rest)
    else $error("scanner state not cleared after end word");

  // a byte word raises the count by at most one
  assert property (@(posedge clk) disable iff (rst)
                   (fire && s1_word.op == OP_BYTE) |=>
                   (count == $past(count) || count == $past(count) + 1'b1))
    else $error("count moved by more than one");

  // a full count stays full until the file ends
  assert property (@(posedge clk) disable iff (rst)
                   (status.count_full && !(fire && s1_word.op == OP_END)) |=> status.count_full)
    else $error("saturated count wrapped");

endmodule

// ===== rtl/slc_scan.sv =====
// scanner state and single-pass update for one word
module slc_scan import slc_pkg::*; #(
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   fire,
  input  in_word_t               word,
  input  logic                   count_comment_lines,
  output out_word_t              result,
  output logic [COUNT_WIDTH-1:0] count,
  output scan_status_t           status
);

  mode_t                  mode, mode_next;
  logic                   esc, esc_next;
  logic                   has_code, has_code_next;
  logic                   has_cmt, has_cmt_next;
  logic                   seen, seen_next;
  logic [COUNT_WIDTH-1:0] count_next;
  logic [COUNT_WIDTH-1:0] count_upd;

  // next state for the word in the input register
  always_comb begin
    mode_t      m;
    logic       cont;
    logic       close;
    logic       bump;
    logic [7:0] b;
    logic [7:0] closer;

    mode_next     = mode;
    esc_next      = esc;
    has_code_next = has_code;
    has_cmt_next  = has_cmt;
    seen_next     = seen;
    m             = mode;
    cont          = 1'b0;
    close         = 1'b0;
    bump          = 1'b0;
    b             = word.data;
    closer        = (mode == MODE_CHAR) ? CH_SQ : CH_DQ;

    if (word.op == OP_BYTE) begin
      seen_next = 1'b1;
      cont      = 1'b1;
      // pending slash, pending star and line comment
      unique case (mode)
        MODE_SLASH: begin
          if (b == CH_SLASH) begin
            has_cmt_next = 1'b1;
            mode_next    = MODE_LINE;
            cont         = 1'b0;
          end else if (b == CH_STAR) begin
            has_cmt_next = 1'b1;
            mode_next    = MODE_BLOCK;
            cont         = 1'b0;
          end else begin
            has_code_next = 1'b1;
            esc_next      = 1'b0;
            mode_next     = MODE_NORMAL;
            m             = MODE_NORMAL;
          end
        end
        MODE_STAR: begin
          if (b == CH_SLASH) begin
            has_cmt_next = 1'b1;
            mode_next    = MODE_NORMAL;
            cont         = 1'b0;
          end else begin
            mode_next = MODE_BLOCK;
            m         = MODE_BLOCK;
          end
        end
        MODE_LINE: begin
          cont = 1'b0;
          if (b == CH_LF) begin
            close     = 1'b1;
            mode_next = MODE_NORMAL;
          end
        end
        default: begin
        end
      endcase

      // the byte itself, reprocessed where a lookahead failed
      if (cont) begin
        if (b == CH_CR) begin
        end else if (b == CH_LF) begin
          close = 1'b1;
        end else begin
          unique case (m)
            MODE_BLOCK: begin
              has_cmt_next = 1'b1;
              if (b == CH_STAR) mode_next = MODE_STAR;
            end
            MODE_STRING, MODE_CHAR: begin
              has_code_next = 1'b1;
              if (!esc && b == closer) mode_next = MODE_NORMAL;
              esc_next = !esc && (b == CH_BS);
            end
            default: begin
              if (b == CH_SLASH) begin
                mode_next = MODE_SLASH;
              end else if (b == CH_DQ) begin
                mode_next     = MODE_STRING;
                esc_next      = 1'b0;
                has_code_next = 1'b1;
              end else if (b == CH_SQ) begin
                mode_next     = MODE_CHAR;
                esc_next      = 1'b0;
                has_code_next = 1'b1;
              end else if (!(b == CH_SP || b == CH_TAB || b == CH_VT || b == CH_FF)) begin
                has_code_next = 1'b1;
              end
            end
          endcase
        end
      end
    end else if (mode == MODE_LINE) begin
      close = 1'b1;
    end else begin
      // end of file: unterminated last line
      bump = seen && (has_code || mode == MODE_SLASH ||
                      (count_comment_lines && has_cmt));
    end

    // line close
    if (close) begin
      bump          = has_code_next || (count_comment_lines && has_cmt_next);
      has_code_next = 1'b0;
      has_cmt_next  = 1'b0;
    end

    // saturating count
    count_upd = (bump && !(&count)) ? count + 1'b1 : count;

    // end word clears everything after the total is taken
    count_next = count_upd;
    if (word.op == OP_END) begin
      mode_next     = MODE_NORMAL;
      esc_next      = 1'b0;
      has_code_next = 1'b0;
      has_cmt_next  = 1'b0;
      seen_next     = 1'b0;
      count_next    = '0;
    end
  end

  // total clipped to the result width
  generate
    if (COUNT_WIDTH > TOTAL_WIDTH) begin : g_clip
      assign result.total = (|count_upd[COUNT_WIDTH-1:TOTAL_WIDTH]) ? '1 :
                            count_upd[TOTAL_WIDTH-1:0];
    end else begin : g_ext
      assign result.total = TOTAL_WIDTH'(count_upd);
    end
  endgenerate

  assign result.done = word.op;

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mode     <= MODE_NORMAL;
      esc      <= 1'b0;
      has_code <= 1'b0;
      has_cmt  <= 1'b0;
      seen     <= 1'b0;
      count    <= '0;
    end else if (fire) begin
      mode     <= mode_next;
      esc      <= esc_next;
      has_code <= has_code_next;
      has_cmt  <= has_cmt_next;
      seen     <= seen_next;
      count    <= count_next;
    end
  end

  assign status.at_rest    = (mode == MODE_NORMAL) && !esc && !has_code && !has_cmt &&
                             !seen && (count == '0);
  assign status.count_full = &count;

endmodule

// ===== tb/testbench.sv =====
// testbench for the source line counter: directed and random files against a line predictor
module testbench import slc_pkg::*; ();

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic        op;
  logic [7:0]  byte_in;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] line_total;
  logic        file_done;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_data;

  // predictor state: scanner mode, flags, running count and the comment-line switch
  mode_t       pr_mode;
  logic        pr_escape;
  logic        pr_code;
  logic        pr_comment;
  logic        pr_seen;
  logic [31:0] pr_count;
  logic        pr_comments_on;

  // totals still owed by the block, oldest first
  out_word_t   totals_due[$];

  int          err_count;
  int          words_sent;
  bit          gaps_on;
  bit          stalls_on;
  int          long_hold_req;
  int          stall_left;

  // short source fragments: well-formed comments and literals, code and blank lines
  string       snippets[10] = '{
    "/* c */", "// note\n", "\"s\\\"q\"", "'\\''", "x = 1;\n",
    "\n\n", "  \t\n", "/* a\n * b\n */", "a/b", "\"//\" /* \" */ x\n"
  };

  source_line_counter_top dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .op         (op),
    .byte_in    (byte_in),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .line_total (line_total),
    .file_done  (file_done),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  // clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // run limit
  initial begin
    #20000000;
    $display("DONE: errors detected");
    $finish;
  end

  // ---------------- line predictor ----------------

  function automatic void clear_scan();
    pr_mode    = MODE_NORMAL;
    pr_escape  = 1'b0;
    pr_code    = 1'b0;
    pr_comment = 1'b0;
    pr_seen    = 1'b0;
    pr_count   = '0;
  endfunction

  function automatic logic line_counts();
    return pr_code || (pr_comments_on && pr_comment);
  endfunction

  // saturating increment
  function automatic void bump_count();
    if (pr_count != '1) pr_count = pr_count + 1'b1;
  endfunction

  function automatic void close_line();
    if (line_counts()) bump_count();
    pr_code    = 1'b0;
    pr_comment = 1'b0;
  endfunction

  function automatic void literal_byte(logic [7:0] b, logic [7:0] closer);
    pr_code = 1'b1;
    if (!pr_escape && b == closer) pr_mode = MODE_NORMAL;
    pr_escape = !pr_escape && b == CH_BS;
  endfunction

  function automatic void scan_byte(logic [7:0] b);
    pr_seen = 1'b1;
    // pending modes resolve on the byte after a slash or a star
    case (pr_mode)
      MODE_SLASH: begin
        if (b == CH_SLASH || b == CH_STAR) begin
          pr_comment = 1'b1;
          pr_mode = (b == CH_SLASH) ? MODE_LINE : MODE_BLOCK;
          return;
        end
        pr_code   = 1'b1;
        pr_escape = 1'b0;
        pr_mode   = MODE_NORMAL;
      end
      MODE_STAR: begin
        if (b == CH_SLASH) begin
          pr_comment = 1'b1;
          pr_mode = MODE_NORMAL;
          return;
        end
        pr_mode = MODE_BLOCK;
      end
      MODE_LINE: begin
        if (b == CH_LF) begin
          close_line();
          pr_mode = MODE_NORMAL;
        end
        return;
      end
      default: ;
    endcase
    if (b == CH_CR) return;
    if (b == CH_LF) begin
      close_line();
      return;
    end
    case (pr_mode)
      MODE_BLOCK: begin
        pr_comment = 1'b1;
        if (b == CH_STAR) pr_mode = MODE_STAR;
      end
      MODE_STRING: literal_byte(b, CH_DQ);
      MODE_CHAR:   literal_byte(b, CH_SQ);
      default: begin
        if (b == CH_SLASH) begin
          pr_mode = MODE_SLASH;
        end else if (b == CH_DQ || b == CH_SQ) begin
          pr_mode   = (b == CH_DQ) ? MODE_STRING : MODE_CHAR;
          pr_escape = 1'b0;
          pr_code   = 1'b1;
        end else if (!(b == CH_SP || b == CH_TAB || b == CH_VT || b == CH_FF)) begin
          pr_code = 1'b1;
        end
      end
    endcase
  endfunction

  // expected result word for one accepted input word
  function automatic out_word_t predict_word(logic o, logic [7:0] b);
    out_word_t r;
    if (o == OP_BYTE) begin
      scan_byte(b);
    end else if (pr_mode == MODE_LINE) begin
      close_line();
    end else begin
      if (pr_mode == MODE_SLASH) pr_code = 1'b1;
      if (pr_seen && line_counts()) bump_count();
    end
    r.total = pr_count;
    r.done  = o;
    if (o == OP_END) clear_scan();
    return r;
  endfunction

  // ---------------- idling ----------------

  // mostly short, now and then long
  function automatic int pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 2);
    if (r < 94) return $urandom_range(3, 6);
    return $urandom_range(12, 40);
  endfunction

  // result side: check each accepted word, then drive the stall
  always @(posedge clk) begin
    out_word_t want;
    if (!rst && out_valid && !out_stall) begin
      if (totals_due.size() == 0) begin
        $error("result word with nothing expected: line_total=%0d file_done=%0b",
               line_total, file_done);
        err_count++;
      end else begin
        want = totals_due.pop_front();
        if (line_total !== want.total) begin
          $error("line_total mismatch: expected %0d, got %0d", want.total, line_total);
          err_count++;
        end
        if (file_done !== want.done) begin
          $error("file_done mismatch: expected %0b, got %0b", want.done, file_done);
          err_count++;
        end
      end
    end
    if (long_hold_req != 0) begin
      stall_left = long_hold_req;
      long_hold_req = 0;
    end
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else if (stalls_on && $urandom_range(0, 3) == 0) begin
      stall_left = pick_len() - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // ---------------- stimulus helpers ----------------

  // offer one word and hold it until accepted
  task automatic send_word(logic o, logic [7:0] b);
    int gap;
    gap = (gaps_on && $urandom_range(0, 2) == 0) ? pick_len() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    op       <= o;
    byte_in  <= b;
    do @(posedge clk); while (in_stall);
    totals_due.push_back(predict_word(o, b));
    words_sent++;
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_word(OP_BYTE, s[i]);
  endtask

  task automatic end_file();
    send_word(OP_END, 8'($urandom_range(0, 255)));
  endtask

  // wait until every result is in, then let the pipeline settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (totals_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_comment_switch(logic v);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    pr_comments_on = v;
  endtask

  // biased byte: plenty of comment and literal markers, line ends and whitespace
  function automatic logic [7:0] pick_byte();
    int r;
    r = $urandom_range(0, 99);
    if (r < 22) return 8'($urandom_range(8'h61, 8'h7A));
    if (r < 30) return CH_SP;
    if (r < 33) return CH_TAB;
    if (r < 43) return CH_SLASH;
    if (r < 51) return CH_STAR;
    if (r < 56) return CH_DQ;
    if (r < 60) return CH_SQ;
    if (r < 65) return CH_BS;
    if (r < 78) return CH_LF;
    if (r < 82) return CH_CR;
    return 8'($urandom_range(0, 255));
  endfunction

  // one random file: fragments and single bytes, then the end word
  task automatic send_random_file();
    int pieces;
    pieces = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 30);
    repeat (pieces) begin
      if ($urandom_range(0, 9) < 3) send_text(snippets[$urandom_range(0, 9)]);
      else send_word(OP_BYTE, pick_byte());
    end
    end_file();
  endtask

  task automatic run_files(int words);
    int stop_at;
    stop_at = words_sent + words;
    while (words_sent < stop_at) send_random_file();
  endtask

  // ---------------- tests ----------------

  // edge cases of the scanner, comment lines not counted
  task automatic test_directed();
    gaps_on = 1'b1;
    stalls_on = 1'b1;
    // empty file
    end_file();
    // high byte as code, star then other byte inside a block comment, carriage return
    send_word(OP_BYTE, 8'hFF);
    send_text("/*a**/");
    send_word(OP_BYTE, CH_CR);
    send_word(OP_BYTE, CH_LF);
    end_file();
    // escaped quote, newline inside literals, zero byte
    send_text("\"\\\"\n'\n");
    send_word(OP_BYTE, 8'h00);
    end_file();
    // file ending right after a slash
    send_text(" /");
    end_file();
    // file ending inside a line comment
    send_text("\t//x");
    end_file();
  endtask

  task automatic test_random_mix();
    write_comment_switch(1'b0);
    gaps_on = 1'b0;
    stalls_on = 1'b0;
    run_files(300);
    write_comment_switch(1'b1);
    gaps_on = 1'b1;
    stalls_on = 1'b1;
    run_files(500);
    write_comment_switch(1'b0);
    gaps_on = 1'b0;
    stalls_on = 1'b1;
    run_files(300);
    write_comment_switch(1'b1);
    gaps_on = 1'b1;
    stalls_on = 1'b0;
    run_files(300);
  endtask

  // long receiver hold while words keep coming, then a full drain and a run with gaps and stalls
  task automatic test_backpressure();
    gaps_on = 1'b0;
    stalls_on = 1'b0;
    long_hold_req = 300;
    run_files(100);
    wait_idle();
    gaps_on = 1'b1;
    stalls_on = 1'b1;
    run_files(40);
  endtask

  task automatic test_comment_switch_off();
    write_comment_switch(1'b0);
    gaps_on = 1'b1;
    stalls_on = 1'b1;
    run_files(210);
  endtask

  // ---------------- main sequence ----------------
  initial begin
    rst       = 1'b1;
    in_valid  = 1'b0;
    op        = OP_BYTE;
    byte_in   = 8'h00;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_data  = 1'b0;
    err_count = 0;
    words_sent = 0;
    gaps_on = 1'b0;
    stalls_on = 1'b0;
    long_hold_req = 0;
    stall_left = 0;
    pr_comments_on = 1'b0;
    clear_scan();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_random_mix();
    test_backpressure();
    test_comment_switch_off();

    // drain and settle
    stalls_on = 1'b0;
    wait_idle();
    repeat (10) @(posedge clk);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== source_line_counter_top.f =====
rtl/slc_pkg.sv
rtl/slc_scan.sv
rtl/source_line_counter_top.sv
tb/testbench.sv
